// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define FBA_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fba: same-cycle check failed");

// next-cycle implication, held off during reset
`define FBA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fba: next-cycle check failed");

`endif

// File: rtl/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;

  localparam int FRAME_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] USABLE_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_MARK  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } fba_state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic scan_en;
  } fba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mark_range;
    logic scan_done;
  } fba_stat_t;

endpackage

`default_nettype wire

// File: rtl/fba_ctrl.sv
`default_nettype none

module fba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire fba_pkg::fba_stat_t stat,
  output fba_pkg::fba_cmd_t  cmd,
  output logic               busy
);

  fba_pkg::fba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fba_pkg::S_CLEAR: begin
        if (stat.clear_last) state_next = fba_pkg::S_IDLE;
      end
      fba_pkg::S_IDLE: begin
        if (start && !stat.mark_range) state_next = fba_pkg::S_SCAN;
      end
      fba_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = fba_pkg::S_IDLE;
      end
      default: state_next = fba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      fba_pkg::S_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      fba_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      fba_pkg::S_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/fba_datapath.sv
`default_nettype none

module fba_datapath #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fba_pkg::fba_cmd_t            cmd,
  output fba_pkg::fba_stat_t                stat,
  input  wire logic                         operation,
  input  wire logic [fba_pkg::FRAME_W-1:0]  frame_index,
  input  wire logic                         usable_frames_we,
  input  wire logic [fba_pkg::COUNT_W-1:0]  usable_frames,
  output logic                              done,
  output logic [fba_pkg::FRAME_W-1:0]       result_frame,
  output logic [fba_pkg::STATUS_W-1:0]      status
);

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW   = $clog2(WORD_BITS);
  localparam int SPAN = WORD_COUNT * WORD_BITS;
  localparam int FW   = $clog2(SPAN + 1);
  localparam int CW   = (FW > fba_pkg::COUNT_W) ? FW : fba_pkg::COUNT_W;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata;
  logic [WAW-1:0]       w;
  logic [WAW-1:0]       rd_addr;
  logic [FW-1:0]        base;
  logic                 op;
  logic [fba_pkg::FRAME_W-1:0] idx;
  logic [fba_pkg::COUNT_W-1:0] usable;

  logic [CW-1:0] usable_ext, max_ext, limit, base_ext, base_top, rem;
  logic [WORD_BITS-1:0] vmask, masked, set_word;
  logic [PW-1:0] alloc_pos, mark_pos, set_pos;
  logic [CW-1:0] alloc_frame;
  logic found, mark_hit, scan_ok, last_scan;

  assign usable_ext = CW'(usable);
  assign max_ext    = CW'(MAX_FRAMES);
  assign limit      = (usable_ext > max_ext) ? max_ext : usable_ext;
  assign base_ext   = CW'(base);
  assign base_top   = base_ext + CW'(WORD_BITS);
  assign rem        = (limit > base_ext) ? (limit - base_ext) : '0;

  assign stat.mark_range = (operation == fba_pkg::OP_MARK) && (CW'(frame_index) >= limit);
  assign stat.clear_last = (w == LAST_WORD);

  // frames at or above the limit count as taken
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      vmask[b] = (CW'(b) < rem);
    end
  end

  assign masked = rdata | ~vmask;
  assign found  = ~&masked;

  always_comb begin
    alloc_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) alloc_pos = PW'(b);
    end
  end

  assign mark_hit    = CW'(idx) < base_top;
  assign mark_pos    = PW'(CW'(idx) - base_ext);
  assign alloc_frame = base_ext + CW'(alloc_pos);
  assign scan_ok     = (op == fba_pkg::OP_MARK) ? mark_hit : found;
  assign last_scan   = (w == LAST_WORD) || (base_top >= limit);
  assign stat.scan_done = (op == fba_pkg::OP_MARK) ? mark_hit : (found || last_scan);
  assign set_pos     = (op == fba_pkg::OP_MARK) ? mark_pos : alloc_pos;
  assign set_word    = rdata | (WORD_BITS'(1) << set_pos);

  // read one word ahead so each scan cycle sees the word at w
  always_comb begin
    if (cmd.accept) begin
      rd_addr = '0;
    end else if (w == LAST_WORD) begin
      rd_addr = w;
    end else begin
      rd_addr = w + WAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.clear_en) begin
      mem[w] <= '0;
    end else if (cmd.scan_en && scan_ok) begin
      mem[w] <= set_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w      <= '0;
      usable <= fba_pkg::USABLE_RESET;
      done   <= 1'b0;
    end else begin
      if (usable_frames_we) usable <= usable_frames;
      if (cmd.clear_en || cmd.scan_en) begin
        w <= w + WAW'(1);
      end else if (cmd.accept) begin
        w <= '0;
      end
      done <= (cmd.accept && stat.mark_range) || (cmd.scan_en && stat.scan_done);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= operation;
      idx  <= frame_index;
      base <= '0;
    end else if (cmd.scan_en) begin
      base <= FW'(base_top);
    end
    if (cmd.accept && stat.mark_range) begin
      result_frame <= '0;
      status       <= fba_pkg::STATUS_RANGE;
    end else if (cmd.scan_en && stat.scan_done) begin
      if (!scan_ok) begin
        result_frame <= '0;
        status       <= fba_pkg::STATUS_FULL;
      end else if (op == fba_pkg::OP_MARK) begin
        result_frame <= idx;
        status       <= fba_pkg::STATUS_OK;
      end else begin
        result_frame <= fba_pkg::FRAME_W'(alloc_frame);
        status       <= fba_pkg::STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/frame_bitmap_allocator.sv
`default_nettype none

// Bitmap frame allocator, one bit per frame, lowest free frame first. A
// transaction is taken when start is high and busy is low; its result shows
// on result_frame/status for exactly one cycle with done high, and the
// receiver cannot stall it. Each transaction has an accept cycle and then
// examines bitmap words in turn, the word memory being read one word per
// cycle from word 0: an allocate scans at most ceil(MAX_FRAMES/WORD_BITS)
// words, 64 by default, a mark of frame f scans words 0 to f/WORD_BITS, and
// a mark out of range reports in the cycle after accept. After reset the
// bitmap is cleared by a pass over all ceil(MAX_FRAMES/WORD_BITS) words with
// busy high; usable_frames writes are taken at any time but belong only to
// idle periods.
module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         operation,
  input  wire logic [fba_pkg::FRAME_W-1:0]  frame_index,
  input  wire logic                         usable_frames_we,
  input  wire logic [fba_pkg::COUNT_W-1:0]  usable_frames,
  output logic                              done,
  output logic [fba_pkg::FRAME_W-1:0]       result_frame,
  output logic [fba_pkg::STATUS_W-1:0]      status
);

  fba_pkg::fba_cmd_t  cmd;
  fba_pkg::fba_stat_t stat;

  fba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fba_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .frame_index      (frame_index),
    .usable_frames_we (usable_frames_we),
    .usable_frames    (usable_frames),
    .done             (done),
    .result_frame     (result_frame),
    .status           (status)
  );

endmodule

`default_nettype wire

// File: rtl/fba_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fba_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         operation,
  input wire logic [fba_pkg::FRAME_W-1:0]  frame_index,
  input wire logic                         done,
  input wire logic [fba_pkg::FRAME_W-1:0]  result_frame,
  input wire logic [fba_pkg::STATUS_W-1:0] status
);

  logic                        mark_op;
  logic [fba_pkg::FRAME_W-1:0] mark_idx;
  logic                        mark_ok;
  logic                        failed;
  logic                        status_legal;

  // last accepted transaction, for the echo check
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mark_op  <= (operation == fba_pkg::OP_MARK);
      mark_idx <= frame_index;
    end
  end

  assign mark_ok      = done && mark_op && (status == fba_pkg::STATUS_OK);
  assign failed       = done && (status != fba_pkg::STATUS_OK);
  assign status_legal = (status == fba_pkg::STATUS_OK) || (status == fba_pkg::STATUS_FULL) ||
                        (status == fba_pkg::STATUS_RANGE);

  `FBA_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  `FBA_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `FBA_ASSERT_IMPLY(a_fail_zero, clk, rst, failed, result_frame == '0)
  `FBA_ASSERT_IMPLY(a_mark_echo, clk, rst, mark_ok, result_frame == mark_idx)
  `FBA_ASSERT_IMPLY(a_status_legal, clk, rst, done, status_legal)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

`default_nettype wire
